>>> rtl/prts_pkg.sv
// Package for the priority round-robin task scheduler.
// Shared types, event codes and constants; no dependencies.
package prts_pkg;
    localparam int MaxTasks    = 16;
    localparam int MutexCount  = 4;
    localparam int TickBits    = 32;
    localparam logic [7:0] IdlePrio = 8'd255;

    typedef enum logic [2:0] {
        FN_CREATE  = 3'd0,
        FN_ACTIVATE = 3'd1,
        FN_TERM    = 3'd2,
        FN_WAIT    = 3'd3,
        FN_TICK    = 3'd4,
        FN_ACQ     = 3'd5,
        FN_REL     = 3'd6,
        FN_NOP     = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        MD_SUSP  = 2'd0,
        MD_READY = 2'd1,
        MD_RUN   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_WAITER  = 2'd2,
        ST_NOSLOT  = 2'd3
    } t_status;

    typedef struct packed {
        t_func        func;
        logic [3:0]   task_id;
        logic [7:0]   priority_req;
        logic [31:0]  wait_ticks;
        logic [1:0]   mutex_id;
    } t_event;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_APPLY, SQ_TICK, SQ_BEST, SQ_PICK, SQ_OUT
    } t_seq_state;
endpackage

>>> rtl/priority_round_robin_task_scheduler.sv
// Top level of the priority round-robin task scheduler. Each event passes through the
// apply step, the slot-serial tick scan for a tick, the slot-serial best-priority scan
// and the pick scan, which stops at the first hit, before its result is valid.
// The back end finishes one event before it takes the next; a two-entry queue decouples
// input, and a result waiting on m_axis_tready holds the back end.
// Reset (synchronous, active low): idle task running, no others created.
module priority_round_robin_task_scheduler #(
    parameter int MAX_TASKS   = prts_pkg::MaxTasks,
    parameter int MUTEX_COUNT = prts_pkg::MutexCount,
    parameter int TICK_BITS   = prts_pkg::TickBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], task_id[6:3], priority_req[14:7], wait_ticks[46:15], mutex_id[48:47]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running_task[3:0], switched[4], created_id[8:5], status[10:9]
    output logic [15:0] m_axis_tdata
);
    import prts_pkg::*;
    logic   r_enable;
    t_event w_in, w_qev;
    logic   w_qv, w_pop;
    logic [3:0] w_run, w_cid;
    logic [1:0] w_stat;
    logic       w_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_enable <= 1'b0;
        else if (i_cfg_we) r_enable <= i_cfg_wdata;
    end

    assign w_in.func         = t_func'(s_axis_tdata[2:0]);
    assign w_in.task_id      = s_axis_tdata[6:3];
    assign w_in.priority_req = s_axis_tdata[14:7];
    assign w_in.wait_ticks   = s_axis_tdata[46:15];
    assign w_in.mutex_id     = s_axis_tdata[48:47];

    prts_front u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
        .i_event(w_in), .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_event(w_qev)
    );

    prts_core #(.MAX_TASKS(MAX_TASKS), .MUTEX_COUNT(MUTEX_COUNT),
                .TICK_BITS(TICK_BITS)) u_core (
        .i_clk, .i_rst_n, .i_enable(r_enable), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_event(w_qev), .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_running_task(w_run), .o_switched(w_sw), .o_created_id(w_cid),
        .o_status(w_stat)
    );

    assign m_axis_tdata = {5'd0, w_stat, w_cid, w_sw, w_run};
endmodule

>>> rtl/prts_front.sv
// Front end: accepts event transactions and queues them.
// Depends on prts_pkg.
module prts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  prts_pkg::t_event  i_event,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output prts_pkg::t_event  o_q_event
);
    import prts_pkg::*;
    t_event     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign o_q_event     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_event;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

>>> rtl/prts_core.sv
// Back end: task table, mutexes, tick scan and round-robin pick sequencer.
// Depends on prts_pkg.
module prts_core #(
    parameter int MAX_TASKS   = prts_pkg::MaxTasks,
    parameter int MUTEX_COUNT = prts_pkg::MutexCount,
    parameter int TICK_BITS   = prts_pkg::TickBits
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_enable,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  prts_pkg::t_event  i_event,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [3:0]        o_running_task,
    output logic              o_switched,
    output logic [3:0]        o_created_id,
    output logic [1:0]        o_status
);
    import prts_pkg::*;
    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int MW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

    t_seq_state r_st, n_st;
    logic [7:0]           r_prio    [MAX_TASKS];
    t_mode                r_mode    [MAX_TASKS];
    logic                 r_blk     [MAX_TASKS];
    logic [TICK_BITS-1:0] r_wait    [MAX_TASKS];
    logic [CW-1:0]        r_created;
    logic [SW-1:0]        r_cur;
    logic                 r_hv [MUTEX_COUNT];
    logic [SW-1:0]        r_hs [MUTEX_COUNT];
    logic                 r_pv [MUTEX_COUNT];
    logic [SW-1:0]        r_ps [MUTEX_COUNT];
    t_event               r_ev;
    logic [SW:0]          r_k;
    logic [8:0]           r_best;
    logic                 r_found;
    logic [SW-1:0]        r_next;
    logic [1:0]           r_status;
    logic [3:0]           r_cid;
    logic                 r_ovalid;
    logic [3:0]           r_orun;
    logic                 r_osw;
    logic [3:0]           r_ocid;
    logic [1:0]           r_ostat;

    logic [SW-1:0] w_idx, w_scan, w_pidx;
    logic [SW:0]   w_psum;
    logic          w_tid_ok, w_mid_ok, w_slot_ok, w_cand;
    logic [MW-1:0] w_mid;
    logic          w_out_free;
    logic [TICK_BITS-1:0] w_ticks, w_dec;
    t_status       w_status;
    logic [3:0]    w_cid;

    assign w_mid    = MW'(r_ev.mutex_id);
    assign w_tid_ok = 32'(r_ev.task_id) < 32'(r_created);
    assign w_mid_ok = 32'(r_ev.mutex_id) < MUTEX_COUNT;
    assign w_idx    = SW'(r_ev.task_id);
    assign w_scan   = r_k[SW-1:0];
    assign w_slot_ok = 32'(w_scan) < 32'(r_created);
    assign w_cand   = w_slot_ok && (r_mode[w_scan] != MD_SUSP);
    assign w_ticks  = TICK_BITS'(r_ev.wait_ticks);
    assign w_dec    = r_wait[w_scan] - 1'b1;
    assign w_out_free = !r_ovalid || i_res_ready;
    assign o_q_pop  = (r_st == SQ_IDLE) && i_q_valid;
    // cyclic slot after the current one, wrapped at the slot count
    assign w_psum   = {1'b0, r_cur} + r_k;
    assign w_pidx   = (32'(w_psum) >= MAX_TASKS) ? SW'(32'(w_psum) - MAX_TASKS)
                                                 : SW'(w_psum);

    assign o_res_valid    = r_ovalid;
    assign o_running_task = r_orun;
    assign o_switched     = r_osw;
    assign o_created_id   = r_ocid;
    assign o_status       = r_ostat;

    always_comb begin
        w_status = ST_OK;
        w_cid    = '0;
        case (r_ev.func) inside
            FN_CREATE: begin
                if (32'(r_created) >= MAX_TASKS) w_status = ST_FULL;
                else w_cid = 4'(r_created);
            end
            FN_ACTIVATE, FN_TERM, FN_WAIT: begin
                if (!w_tid_ok) w_status = ST_NOSLOT;
            end
            FN_ACQ: begin
                if (!w_tid_ok) w_status = ST_NOSLOT;
                else if (w_mid_ok && r_hv[w_mid] && r_hs[w_mid] != w_idx && r_pv[w_mid])
                    w_status = ST_WAITER;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            SQ_IDLE:  if (i_q_valid) n_st = SQ_APPLY;
            SQ_APPLY: n_st = (r_ev.func == FN_TICK) ? SQ_TICK : SQ_BEST;
            SQ_TICK:  if (32'(r_k) == MAX_TASKS - 1) n_st = SQ_BEST;
            SQ_BEST:  if (32'(r_k) == MAX_TASKS - 1) n_st = SQ_PICK;
            SQ_PICK:  if (r_found || 32'(r_k) == MAX_TASKS) n_st = SQ_OUT;
            SQ_OUT:   if (w_out_free) n_st = SQ_IDLE;
            default:  n_st = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SQ_IDLE;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_mode[i] <= MD_SUSP;
                r_blk[i]  <= 1'b0;
                r_wait[i] <= '0;
            end
            r_prio[0] <= IdlePrio;
            r_mode[0] <= MD_RUN;
            r_created <= CW'(1);
            r_cur <= '0;
            for (int m = 0; m < MUTEX_COUNT; m++) begin
                r_hv[m] <= 1'b0;
                r_pv[m] <= 1'b0;
            end
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == SQ_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                SQ_IDLE: begin
                    r_ev <= i_event;
                    r_k  <= '0;
                end
                SQ_APPLY: begin
                    r_status <= w_status;
                    r_cid    <= w_cid;
                    r_k      <= '0;
                    r_best   <= 9'd256;
                    case (r_ev.func) inside
                        FN_CREATE: begin
                            if (32'(r_created) < MAX_TASKS) begin
                                r_prio[SW'(r_created)] <= r_ev.priority_req;
                                r_mode[SW'(r_created)] <= MD_SUSP;
                                r_blk[SW'(r_created)]  <= 1'b0;
                                r_wait[SW'(r_created)] <= '0;
                                r_created <= r_created + 1'b1;
                            end
                        end
                        FN_ACTIVATE, FN_TERM, FN_WAIT: begin
                            if (!w_tid_ok) begin
                            end else if (r_ev.func == FN_ACTIVATE) begin
                                if (r_mode[w_idx] == MD_SUSP) r_mode[w_idx] <= MD_READY;
                                r_blk[w_idx]  <= 1'b0;
                                r_wait[w_idx] <= '0;
                            end else if (r_ev.func == FN_TERM) begin
                                r_mode[w_idx] <= MD_SUSP;
                                r_blk[w_idx]  <= 1'b0;
                                r_wait[w_idx] <= '0;
                            end else begin
                                r_wait[w_idx] <= (w_ticks == '0) ? TICK_BITS'(1) : w_ticks;
                                r_blk[w_idx]  <= 1'b1;
                                r_mode[w_idx] <= MD_SUSP;
                            end
                        end
                        FN_ACQ: begin
                            if (w_tid_ok && w_mid_ok) begin
                                if (!r_hv[w_mid]) begin
                                    r_hv[w_mid] <= 1'b1;
                                    r_hs[w_mid] <= w_idx;
                                end else if (r_hs[w_mid] != w_idx && !r_pv[w_mid]) begin
                                    r_pv[w_mid] <= 1'b1;
                                    r_ps[w_mid] <= w_idx;
                                    r_mode[w_idx] <= MD_SUSP;
                                end
                            end
                        end
                        FN_REL: begin
                            if (w_mid_ok && r_hv[w_mid]) begin
                                if (r_pv[w_mid]) begin
                                    r_hs[w_mid] <= r_ps[w_mid];
                                    r_pv[w_mid] <= 1'b0;
                                    if (r_mode[r_ps[w_mid]] == MD_SUSP)
                                        r_mode[r_ps[w_mid]] <= MD_READY;
                                end else begin
                                    r_hv[w_mid] <= 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                SQ_TICK: begin
                    if (w_slot_ok && r_mode[w_scan] == MD_SUSP && r_blk[w_scan]) begin
                        r_wait[w_scan] <= w_dec;
                        if (w_dec == '0) begin
                            r_blk[w_scan]  <= 1'b0;
                            r_mode[w_scan] <= MD_READY;
                        end
                    end
                    r_k <= (32'(r_k) == MAX_TASKS - 1) ? '0 : r_k + 1'b1;
                end
                SQ_BEST: begin
                    if (w_cand && {1'b0, r_prio[w_scan]} < r_best)
                        r_best <= {1'b0, r_prio[w_scan]};
                    if (32'(r_k) == MAX_TASKS - 1) begin
                        r_k <= (SW+1)'(1);
                        r_found <= 1'b0;
                        r_next <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                SQ_PICK: begin
                    if (!r_found && 32'(r_k) <= MAX_TASKS) begin
                        if (r_mode[w_pidx] != MD_SUSP
                            && 32'(w_pidx) < 32'(r_created)
                            && {1'b0, r_prio[w_pidx]} == r_best) begin
                            r_found <= 1'b1;
                            r_next  <= w_pidx;
                        end
                        r_k <= r_k + 1'b1;
                    end
                end
                SQ_OUT: begin
                    if (w_out_free) begin
                        logic [SW-1:0] nx;
                        nx = (i_enable && r_best != 9'd256) ? r_next : '0;
                        if (!i_enable || r_best == 9'd256) r_blk[0] <= 1'b0;
                        if (nx != r_cur && r_mode[r_cur] == MD_RUN)
                            r_mode[r_cur] <= MD_READY;
                        r_mode[nx] <= MD_RUN;
                        r_cur    <= nx;
                        r_orun   <= 4'(nx);
                        r_osw    <= (nx != r_cur);
                        r_ocid   <= r_cid;
                        r_ostat  <= r_status;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> test/priority_round_robin_task_scheduler_test.sv
// Testbench for the priority round-robin task scheduler.
// Drives event transactions, predicts each result and checks it field by field.
// Depends on prts_pkg and priority_round_robin_task_scheduler.
`timescale 1ns / 100ps

module priority_round_robin_task_scheduler_test;
    import prts_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles = 400;

    typedef struct packed {
        t_status    status;
        logic [3:0] created_id;
        logic       switched;
        logic [3:0] running_task;
    } t_sched_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    priority_round_robin_task_scheduler dut (.*);

    always #1 i_clk = ~i_clk;

    // scheduler state mirror
    logic [7:0]  sched_prio [MaxTasks];
    t_mode       sched_mode [MaxTasks];
    logic        sched_blocked [MaxTasks];
    logic [31:0] sched_wait [MaxTasks];
    int          sched_count;
    int          sched_cur;
    logic        holder_ok [MutexCount];
    int          holder_slot [MutexCount];
    logic        waiter_ok [MutexCount];
    int          waiter_slot [MutexCount];
    logic        sched_en;

    t_sched_result expected_results[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  sent = 0;
    int  checked = 0;
    int  burst_left = 0;
    bit  hold_off = 1'b0;
    int  hold_count = 0;
    int  stall_mode = 0;

    function automatic int choose_next();
        int best;
        int idx;
        best = 256;
        for (int n = 0; n < sched_count; n++)
            if (sched_mode[n] != MD_SUSP && sched_prio[n] < best) best = sched_prio[n];
        if (best == 256) begin
            sched_blocked[0] = 1'b0;
            return 0;
        end
        for (int k = 1; k <= MaxTasks; k++) begin
            idx = (sched_cur + k) % MaxTasks;
            if (idx < sched_count && sched_mode[idx] != MD_SUSP && sched_prio[idx] == best)
                return idx;
        end
        return 0;
    endfunction

    function automatic t_sched_result schedule_event(t_event ev);
        t_sched_result r;
        int  tid;
        int  mid;
        int  nxt;
        int  h;
        bit  tid_ok;
        tid = ev.task_id;
        mid = ev.mutex_id;
        tid_ok = tid < sched_count;
        r = '0;
        r.status = ST_OK;
        case (ev.func)
            FN_CREATE: begin
                if (sched_count >= MaxTasks) r.status = ST_FULL;
                else begin
                    r.created_id = 4'(sched_count);
                    sched_prio[sched_count] = ev.priority_req;
                    sched_mode[sched_count] = MD_SUSP;
                    sched_blocked[sched_count] = 1'b0;
                    sched_wait[sched_count] = '0;
                    sched_count++;
                end
            end
            FN_ACTIVATE: begin
                if (!tid_ok) r.status = ST_NOSLOT;
                else begin
                    if (sched_mode[tid] == MD_SUSP) sched_mode[tid] = MD_READY;
                    sched_blocked[tid] = 1'b0;
                    sched_wait[tid] = '0;
                end
            end
            FN_TERM: begin
                if (!tid_ok) r.status = ST_NOSLOT;
                else begin
                    sched_mode[tid] = MD_SUSP;
                    sched_blocked[tid] = 1'b0;
                    sched_wait[tid] = '0;
                end
            end
            FN_WAIT: begin
                if (!tid_ok) r.status = ST_NOSLOT;
                else begin
                    sched_wait[tid] = (ev.wait_ticks == 0) ? 32'd1 : ev.wait_ticks;
                    sched_blocked[tid] = 1'b1;
                    sched_mode[tid] = MD_SUSP;
                end
            end
            FN_TICK: begin
                for (int n = 0; n < sched_count; n++)
                    if (sched_mode[n] == MD_SUSP && sched_blocked[n]) begin
                        sched_wait[n] = sched_wait[n] - 32'd1;
                        if (sched_wait[n] == 0) begin
                            sched_blocked[n] = 1'b0;
                            sched_mode[n] = MD_READY;
                        end
                    end
            end
            FN_ACQ: begin
                if (!tid_ok) r.status = ST_NOSLOT;
                else if (!holder_ok[mid]) begin
                    holder_ok[mid] = 1'b1;
                    holder_slot[mid] = tid;
                end else if (holder_slot[mid] == tid) begin
                end else if (!waiter_ok[mid]) begin
                    waiter_ok[mid] = 1'b1;
                    waiter_slot[mid] = tid;
                    sched_mode[tid] = MD_SUSP;
                end else r.status = ST_WAITER;
            end
            FN_REL: begin
                if (holder_ok[mid]) begin
                    if (waiter_ok[mid]) begin
                        h = waiter_slot[mid];
                        holder_slot[mid] = h;
                        waiter_ok[mid] = 1'b0;
                        waiter_slot[mid] = 0;
                        if (sched_mode[h] == MD_SUSP) sched_mode[h] = MD_READY;
                    end else begin
                        holder_ok[mid] = 1'b0;
                        holder_slot[mid] = 0;
                    end
                end
            end
            default: ;
        endcase
        if (sched_en) nxt = choose_next();
        else begin
            nxt = 0;
            sched_blocked[0] = 1'b0;
        end
        if (nxt != sched_cur && sched_mode[sched_cur] == MD_RUN)
            sched_mode[sched_cur] = MD_READY;
        sched_mode[nxt] = MD_RUN;
        r.running_task = 4'(nxt);
        r.switched = (nxt != sched_cur);
        sched_cur = nxt;
        return r;
    endfunction

    task automatic reset_mirror();
        for (int n = 0; n < MaxTasks; n++) begin
            sched_prio[n] = '0;
            sched_mode[n] = MD_SUSP;
            sched_blocked[n] = 1'b0;
            sched_wait[n] = '0;
        end
        sched_prio[0] = IdlePrio;
        sched_mode[0] = MD_RUN;
        sched_count = 1;
        sched_cur = 0;
        for (int m = 0; m < MutexCount; m++) begin
            holder_ok[m] = 1'b0;
            holder_slot[m] = 0;
            waiter_ok[m] = 1'b0;
            waiter_slot[m] = 0;
        end
        sched_en = 1'b0;
    endtask

    // sends one event, with random bursts and gaps; tvalid stays up within a burst
    task automatic send_event(t_func f, logic [3:0] tid, logic [7:0] prio,
                              logic [31:0] ticks, logic [1:0] mid);
        t_event ev;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        ev.func = f;
        ev.task_id = tid;
        ev.priority_req = prio;
        ev.wait_ticks = ticks;
        ev.mutex_id = mid;
        s_axis_tdata <= {7'd0, ev.mutex_id, ev.wait_ticks, ev.priority_req, ev.task_id,
                         ev.func};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(schedule_event(ev));
        sent++;
    endtask

    task automatic send_random(int wellformed);
        t_func f;
        logic [3:0] tid;
        if (wellformed != 0 && sched_count > 1) tid = 4'($urandom_range(0, sched_count - 1));
        else tid = 4'($urandom);
        f = t_func'($urandom_range(0, 7));
        send_event(f, tid, 8'($urandom), ($urandom_range(0, 3) == 0) ? $urandom
                   : $urandom_range(0, 4), 2'($urandom));
    endtask

    task automatic drain_and_set(logic en);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sched_en = en;
    endtask

    task automatic test_disabled();
        send_event(FN_CREATE, 4'd0, 8'd10, 32'd0, 2'd0);
        send_event(FN_ACTIVATE, 4'd1, 8'd0, 32'd0, 2'd0);
        send_event(FN_TICK, 4'd0, 8'd0, 32'd0, 2'd0);
        send_event(FN_NOP, 4'hF, 8'hFF, 32'hFFFF_FFFF, 2'd3);
    endtask

    task automatic test_directed();
        send_event(FN_ACTIVATE, 4'd9, 8'd0, 32'd0, 2'd0);
        send_event(FN_CREATE, 4'd0, 8'd0, 32'd0, 2'd0);
        send_event(FN_CREATE, 4'd0, 8'd10, 32'd0, 2'd0);
        send_event(FN_ACTIVATE, 4'd2, 8'd0, 32'd0, 2'd0);
        send_event(FN_ACTIVATE, 4'd3, 8'd0, 32'd0, 2'd0);
        send_event(FN_WAIT, 4'd3, 8'd0, 32'd0, 2'd0);
        send_event(FN_TICK, 4'd0, 8'd0, 32'd0, 2'd0);
        send_event(FN_WAIT, 4'd1, 8'd0, 32'hFFFF_FFFF, 2'd0);
        send_event(FN_ACQ, 4'd2, 8'd0, 32'd0, 2'd3);
        send_event(FN_ACQ, 4'd2, 8'd0, 32'd0, 2'd3);
        send_event(FN_ACQ, 4'd3, 8'd0, 32'd0, 2'd3);
        send_event(FN_ACQ, 4'd0, 8'd0, 32'd0, 2'd3);
        send_event(FN_REL, 4'd0, 8'd0, 32'd0, 2'd3);
        send_event(FN_REL, 4'd0, 8'd0, 32'd0, 2'd3);
        send_event(FN_REL, 4'd0, 8'd0, 32'd0, 2'd1);
        send_event(FN_TERM, 4'd3, 8'd0, 32'd0, 2'd0);
        send_event(FN_ACTIVATE, 4'd1, 8'd0, 32'd0, 2'd0);
        send_event(FN_TERM, 4'd0, 8'd0, 32'd0, 2'd0);
        for (int n = 0; n < 13; n++) send_event(FN_CREATE, 4'd0, 8'd255, 32'd0, 2'd0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 8; n++) send_random(1);
        hold_off = 1'b0;
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_random($urandom_range(0, 9) != 0);
    endtask

    // receiver: one long hold-off when requested, then its own stall pattern
    always @(posedge i_clk) begin
        if (hold_off && hold_count < HoldCycles) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 3) != 0;
                default: m_axis_tready <= $urandom_range(0, 3) == 0;
            endcase
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        end
    end

    // checks each result against the oldest prediction
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[10:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                checked++;
                if (got.running_task !== want.running_task)
                    begin $display("%0t: running_task exp %0d got %0d", $time,
                                   want.running_task, got.running_task); errors++; end
                if (got.switched !== want.switched)
                    begin $display("%0t: switched exp %0d got %0d", $time,
                                   want.switched, got.switched); errors++; end
                if (got.created_id !== want.created_id)
                    begin $display("%0t: created_id exp %0d got %0d", $time,
                                   want.created_id, got.created_id); errors++; end
                if (got.status !== want.status)
                    begin $display("%0t: status exp %0d got %0d", $time,
                                   want.status, got.status); errors++; end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        reset_mirror();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_disabled();
        for (int phase = 0; phase < 4; phase++) begin
            drain_and_set(phase != 2);
            while (!sched_en && expected_results.size() == 0 && phase == 2) break;
            if (phase == 0) test_directed();
            if (phase == 1) test_backpressure();
            test_random(400);
            // fresh table for the next phase through a free slot reset is not allowed,
            // so terminate every task but the idle task in slot 0 to keep the scan meaningful
            for (int n = 1; n < sched_count; n++)
                send_event(FN_TERM, 4'(n), 8'd0, 32'd0, 2'd0);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d events, checked %0d results across enable on and off phases.",
                 sent, checked);
        if (errors == 0 && expected_results.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
